/* sv/multi_mode_crc_checksum_unit_macros.svh */
// ----------------------------------------------------------------------------
// multi_mode_crc_checksum_unit_macros.svh
// Assertion macros for the CRC / checksum unit. Empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef MULTI_MODE_CRC_CHECKSUM_UNIT_MACROS_SVH
`define MULTI_MODE_CRC_CHECKSUM_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define MMCRC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mmcrc: same-cycle check failed");
// antecedent implies consequent in the next cycle
`define MMCRC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mmcrc: next-cycle check failed");
`else
`define MMCRC_ASSERT_NOW(lbl, ante, cons)
`define MMCRC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* sv/mmcrc_pkg.sv */
// ----------------------------------------------------------------------------
// mmcrc_pkg
// Types, mode codes and CRC helpers shared by the CRC / checksum unit.
// ----------------------------------------------------------------------------
package mmcrc_pkg;

    typedef enum logic [2:0] {
        MODE_CRC8  = 3'd0,
        MODE_CRC16 = 3'd1,
        MODE_CRC32 = 3'd2,
        MODE_SUM8  = 3'd3,
        MODE_SUM16 = 3'd4,
        MODE_SUM32 = 3'd5
    } mode_t;

    localparam logic [2:0] MODE_LIMIT = 3'd6;

    localparam logic       CMD_GENERATE = 1'b0;
    localparam logic       CMD_VERIFY   = 1'b1;

    // CRC register is kept left-aligned in 32 bits for every width
    localparam logic [31:0] POLY8_AL  = 32'h0700_0000;
    localparam logic [31:0] POLY16_AL = 32'h1021_0000;
    localparam logic [31:0] POLY32    = 32'h04C1_1DB7;
    localparam logic [31:0] INIT16_AL = 32'hFFFF_0000;
    localparam logic [31:0] INIT32    = 32'hFFFF_FFFF;

    localparam logic [5:0] BITS8  = 6'd8;
    localparam logic [5:0] BITS16 = 6'd16;
    localparam logic [5:0] BITS32 = 6'd32;

    typedef struct packed {
        logic feed;      // s1 item is consumed this cycle
        logic cfg_write; // mode register write
    } mmcrc_ctrl_t;

    typedef struct packed {
        logic [31:0] value;
        logic [5:0]  bits;
        logic        mismatch;
    } mmcrc_result_t;

    function automatic logic [31:0] crc_init_al(input logic [2:0] mode);
        logic [31:0] v;
        case (mode)
            MODE_CRC16: v = INIT16_AL;
            MODE_CRC32: v = INIT32;
            default:    v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] crc_poly_al(input logic [2:0] mode);
        logic [31:0] v;
        case (mode)
            MODE_CRC16: v = POLY16_AL;
            MODE_CRC32: v = POLY32;
            default:    v = POLY8_AL;
        endcase
        return v;
    endfunction

    function automatic logic [5:0] mode_bits(input logic [2:0] mode);
        logic [5:0] v;
        case (mode) inside
            MODE_CRC8, MODE_SUM8:   v = BITS8;
            MODE_CRC16, MODE_SUM16: v = BITS16;
            default:                v = BITS32;
        endcase
        return v;
    endfunction

endpackage

/* sv/mmcrc_engine.sv */
// ----------------------------------------------------------------------------
// mmcrc_engine
// Mode register, running CRC / sum state and the one-byte update.
// ----------------------------------------------------------------------------
module mmcrc_engine
    import mmcrc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  mmcrc_ctrl_t   ctrl,
    input  logic [2:0]    cfg_wdata,
    input  logic          command,
    input  logic [7:0]    data_byte,
    input  logic [3:0]    valid_bits,
    input  logic          last,
    input  logic [31:0]   received_check,
    output mmcrc_result_t result
);

    logic [2:0]  mode_reg;
    logic [31:0] crc_reg,  crc_next;
    logic [31:0] sum_reg,  sum_next;
    logic [1:0]  biw_reg,  biw_next;

    logic [3:0]  nbits;
    logic [7:0]  byte_m;
    logic [31:0] crc_calc;
    logic [31:0] poly;
    logic [31:0] addend;
    logic [31:0] sum_raw;
    logic [1:0]  biw_adv;
    logic        is_crc;
    logic [31:0] value;
    logic [31:0] mask;

    function automatic logic [31:0] mask_of_mode(input logic [2:0] mode);
        logic [31:0] v;
        case (mode) inside
            MODE_CRC8, MODE_SUM8:   v = 32'h0000_00FF;
            MODE_CRC16, MODE_SUM16: v = 32'h0000_FFFF;
            default:                v = 32'hFFFF_FFFF;
        endcase
        return v;
    endfunction

    assign is_crc = (mode_reg == MODE_CRC8) || (mode_reg == MODE_CRC16) ||
                    (mode_reg == MODE_CRC32);
    assign poly   = crc_poly_al(mode_reg);

    // tail bits only count on the last byte; anything above eight saturates
    assign nbits = (!last || (valid_bits > 4'd8)) ? 4'd8 : valid_bits;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            byte_m[7-i] = data_byte[7-i] & (4'(i) < nbits);
        end
        crc_calc = crc_reg ^ {byte_m, 24'd0};
        for (int i = 0; i < 8; i++)
        begin
            if (4'(i) < nbits)
            begin
                crc_calc = crc_calc[31] ? ({crc_calc[30:0], 1'b0} ^ poly)
                                        : {crc_calc[30:0], 1'b0};
            end
        end
    end

    // big-endian placement of the byte within the current sum word
    always_comb
    begin
        case (mode_reg)
            MODE_SUM16:
            begin
                addend  = biw_reg[0] ? {24'd0, data_byte} : {16'd0, data_byte, 8'd0};
                biw_adv = {1'b0, ~biw_reg[0]};
                mask    = 32'h0000_FFFF;
            end
            MODE_SUM32:
            begin
                case (biw_reg)
                    2'd0:    addend = {data_byte, 24'd0};
                    2'd1:    addend = {8'd0, data_byte, 16'd0};
                    2'd2:    addend = {16'd0, data_byte, 8'd0};
                    default: addend = {24'd0, data_byte};
                endcase
                biw_adv = biw_reg + 2'd1;
                mask    = 32'hFFFF_FFFF;
            end
            default:
            begin
                addend  = {24'd0, data_byte};
                biw_adv = 2'd0;
                mask    = 32'h0000_00FF;
            end
        endcase
        sum_raw = (sum_reg + addend) & mask;
    end

    always_comb
    begin
        crc_next = crc_reg;
        sum_next = sum_reg;
        biw_next = biw_reg;
        if (is_crc)
        begin
            crc_next = crc_calc;
        end
        else if (nbits != 4'd0)
        begin
            sum_next = sum_raw;
            biw_next = biw_adv;
        end
    end

    always_comb
    begin
        case (mode_reg)
            MODE_CRC8:  value = {24'd0, crc_next[31:24]};
            MODE_CRC16: value = {16'd0, crc_next[31:16]};
            MODE_CRC32: value = ~crc_next;
            default:    value = sum_next;
        endcase
        result.value    = value;
        result.bits     = mode_bits(mode_reg);
        result.mismatch = (command == CMD_VERIFY) &&
                          ((received_check & mask_of_mode(mode_reg)) != value);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_CRC8;
            crc_reg  <= '0;
            sum_reg  <= '0;
            biw_reg  <= '0;
        end
        else if (ctrl.cfg_write)
        begin
            // codes past the last mode are dropped
            if (cfg_wdata < MODE_LIMIT)
            begin
                mode_reg <= cfg_wdata;
                crc_reg  <= crc_init_al(cfg_wdata);
                sum_reg  <= '0;
                biw_reg  <= '0;
            end
        end
        else if (ctrl.feed)
        begin
            if (last)
            begin
                crc_reg <= crc_init_al(mode_reg);
                sum_reg <= '0;
                biw_reg <= '0;
            end
            else
            begin
                crc_reg <= crc_next;
                sum_reg <= sum_next;
                biw_reg <= biw_next;
            end
        end
    end

endmodule

/* sv/multi_mode_crc_checksum_unit.sv */
// ----------------------------------------------------------------------------
// multi_mode_crc_checksum_unit
// Byte-wide CRC-8/16/32 and 8/16/32-bit additive checksum, generate or verify.
//
//   channel   signals                                   moves
//   input     in_valid / in_ready + 5 field ports       one message byte
//   output    out_valid / out_ready + 3 field ports     check result (last only)
//   config    cfg_we / cfg_wdata                        mode write, no wait
//
// One item per cycle while input is not held up. An item sits in the input register,
// where the unrolled 8-bit CRC step and the sum adder run, and a last item's result is
// registered for the output. Only a last item waiting on a full, stalled result
// register holds up input. Reset selects CRC-8 and clears all running state.
// ----------------------------------------------------------------------------
`include "multi_mode_crc_checksum_unit_macros.svh"

module multi_mode_crc_checksum_unit
    import mmcrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [7:0]  data_byte,
    input  logic [3:0]  valid_bits,
    input  logic        last,
    input  logic [31:0] received_check,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] check_value,
    output logic [5:0]  check_bits,
    output logic        mismatch
);

    logic        s1_valid_reg;
    logic        s1_cmd_reg;
    logic [7:0]  s1_byte_reg;
    logic [3:0]  s1_vbits_reg;
    logic        s1_last_reg;
    logic [31:0] s1_recv_reg;

    logic        out_valid_reg;
    logic [31:0] out_value_reg;
    logic [5:0]  out_bits_reg;
    logic        out_mismatch_reg;

    logic          out_free;
    logic          s1_move;
    mmcrc_ctrl_t   ctrl;
    mmcrc_result_t result;

    assign out_free = !out_valid_reg || out_ready;
    assign s1_move  = s1_valid_reg && (!s1_last_reg || out_free);
    assign in_ready = !s1_valid_reg || s1_move;

    assign ctrl.feed      = s1_move;
    assign ctrl.cfg_write = cfg_we;

    mmcrc_engine u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .cfg_wdata      (cfg_wdata),
        .command        (s1_cmd_reg),
        .data_byte      (s1_byte_reg),
        .valid_bits     (s1_vbits_reg),
        .last           (s1_last_reg),
        .received_check (s1_recv_reg),
        .result         (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_cmd_reg   <= command;
            s1_byte_reg  <= data_byte;
            s1_vbits_reg <= valid_bits;
            s1_last_reg  <= last;
            s1_recv_reg  <= received_check;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_move && s1_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move && s1_last_reg)
        begin
            out_value_reg    <= result.value;
            out_bits_reg     <= result.bits;
            out_mismatch_reg <= result.mismatch;
        end
    end

    assign out_valid   = out_valid_reg;
    assign check_value = out_value_reg;
    assign check_bits  = out_bits_reg;
    assign mismatch    = out_mismatch_reg;

    `MMCRC_ASSERT_NOW(a_bits_legal, out_valid_reg,
        (out_bits_reg == BITS8) || (out_bits_reg == BITS16) || (out_bits_reg == BITS32))
    `MMCRC_ASSERT_NOW(a_value_fits, out_valid_reg && (out_bits_reg == BITS8),
        out_value_reg[31:8] == 24'd0)
    `MMCRC_ASSERT_NEXT(a_last_lands, s1_move && s1_last_reg, out_valid_reg)
    `MMCRC_ASSERT_NOW(a_stall_cause, s1_valid_reg && !in_ready,
        s1_last_reg && out_valid_reg && !out_ready)

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: regression for multi_mode_crc_checksum_unit
// Drives message bytes in bursts against a stalling receiver and checks every
// check result against a behavioural CRC / checksum engine kept in the bench.
// Directed cases cover each mode, partial and empty tails and ignored mode
// codes. They are followed by random messages, a long receiver hold-off and
// mode writes that abort a message part way through.
// ----------------------------------------------------------------------------
module tb_top;
    import mmcrc_pkg::*;

    localparam int unsigned CYCLE_LIMIT    = 250000;
    localparam int unsigned RANDOM_ITEMS   = 600;
    localparam int unsigned HOLDOFF_CYCLES = 300;
    localparam int unsigned DRAIN_CYCLES   = 4;
    localparam logic [3:0]  FULL_BYTE      = 4'd8;
    localparam logic [2:0]  MODE_SPARE_LO  = MODE_LIMIT;
    localparam logic [2:0]  MODE_SPARE_HI  = 3'(MODE_LIMIT + 3'd1);

    localparam logic [31:0] CRC8_POLY   = 32'h0000_0007;
    localparam logic [31:0] CRC16_POLY  = 32'h0000_1021;
    localparam logic [31:0] CRC32_POLY  = 32'h04C1_1DB7;
    localparam logic [31:0] CRC16_INIT  = 32'h0000_FFFF;
    localparam logic [31:0] CRC32_INIT  = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC32_XOUT  = 32'hFFFF_FFFF;

    typedef struct packed {
        mode_t       mode;
        logic [31:0] crc;
        logic [31:0] acc;
        logic [1:0]  pos;
    } checksum_state_t;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  data;
        logic [3:0]  vbits;
        logic        last;
        logic [31:0] rx;
    } msg_byte_t;

    typedef struct packed {
        checksum_state_t next;
        logic            emit;
        mmcrc_result_t   res;
    } checksum_step_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_wdata = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        command = CMD_GENERATE;
    logic [7:0]  data_byte = '0;
    logic [3:0]  valid_bits = '0;
    logic        last = 1'b0;
    logic [31:0] received_check = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] check_value;
    logic [5:0]  check_bits;
    logic        mismatch;

    checksum_state_t checksum_state;
    mmcrc_result_t   pending_results[$];
    int unsigned     error_count = 0;
    int unsigned     cycle_count = 0;
    int unsigned     bytes_sent = 0;
    int unsigned     burst_left = 0;
    bit              sender_gaps = 1'b1;
    bit              holdoff_request = 1'b0;
    int unsigned     holdoff_left = 0;

    multi_mode_crc_checksum_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .data_byte      (data_byte),
        .valid_bits     (valid_bits),
        .last           (last),
        .received_check (received_check),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .check_value    (check_value),
        .check_bits     (check_bits),
        .mismatch       (mismatch)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // behavioural engine
    // ------------------------------------------------------------------------
    function automatic int unsigned width_of(mode_t m);
        int unsigned w;
        case (m) inside
            MODE_CRC8, MODE_SUM8:   w = 8;
            MODE_CRC16, MODE_SUM16: w = 16;
            default:                w = 32;
        endcase
        return w;
    endfunction

    function automatic logic [31:0] value_mask(mode_t m);
        int unsigned w;
        w = width_of(m);
        return (w == 32) ? 32'hFFFF_FFFF : ((32'h1 << w) - 32'h1);
    endfunction

    function automatic checksum_state_t fresh_checksum(mode_t m);
        checksum_state_t s;
        s.mode = m;
        case (m)
            MODE_CRC16: s.crc = CRC16_INIT;
            MODE_CRC32: s.crc = CRC32_INIT;
            default:    s.crc = '0;
        endcase
        s.acc = '0;
        s.pos = '0;
        return s;
    endfunction

    function automatic checksum_step_t advance_checksum(checksum_state_t st, msg_byte_t it);
        checksum_step_t r;
        int unsigned    w;
        int unsigned    nbits;
        int unsigned    per_word;
        int unsigned    slot;
        int unsigned    i;
        logic [31:0]    mask;
        logic [31:0]    top;
        logic [31:0]    poly;
        logic [31:0]    value;
        logic [7:0]     keep;
        bit             is_crc;
        r.next = st;
        r.emit = 1'b0;
        r.res = '0;
        w = width_of(st.mode);
        mask = value_mask(st.mode);
        is_crc = (st.mode == MODE_CRC8 || st.mode == MODE_CRC16 || st.mode == MODE_CRC32);
        // the tail count only matters on the last byte, and saturates at a byte
        nbits = (!it.last || it.vbits > FULL_BYTE) ? 8 : it.vbits;
        if (is_crc && nbits != 0)
        begin
            top = 32'h1 << (w - 1);
            case (st.mode)
                MODE_CRC16: poly = CRC16_POLY;
                MODE_CRC32: poly = CRC32_POLY;
                default:    poly = CRC8_POLY;
            endcase
            keep = 8'hFF << (8 - nbits);
            r.next.crc = st.crc ^ ({24'h0, it.data & keep} << (w - 8));
            for (i = 0; i < nbits; i++)
            begin
                if ((r.next.crc & top) != 0)
                    r.next.crc = ((r.next.crc << 1) ^ poly) & mask;
                else
                    r.next.crc = (r.next.crc << 1) & mask;
            end
        end
        else if (!is_crc && nbits != 0)
        begin
            // big-endian word: first byte lands in the top lane
            per_word = w / 8;
            slot = st.pos % per_word;
            r.next.acc = (st.acc + ({24'h0, it.data} << (8 * (per_word - 1 - slot)))) & mask;
            r.next.pos = 2'((slot + 1) % per_word);
        end
        if (it.last)
        begin
            if (is_crc)
                value = (st.mode == MODE_CRC32) ? (r.next.crc ^ CRC32_XOUT) : r.next.crc;
            else
                value = r.next.acc;
            value &= mask;
            r.emit = 1'b1;
            r.res.value = value;
            r.res.bits = 6'(w);
            r.res.mismatch = (it.cmd == CMD_VERIFY) && ((it.rx & mask) != value);
            r.next = fresh_checksum(st.mode);
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // receiver side
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns  %s: got %h, expected %h", $time, what, got, want);
        error_count++;
    endtask

    always @(posedge clk)
    begin : check_results
        mmcrc_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with none pending", check_value, '0);
            else
            begin
                want = pending_results.pop_front();
                if (check_value !== want.value)
                    report_mismatch("check_value", check_value, want.value);
                if (check_bits !== want.bits)
                    report_mismatch("check_bits", 32'(check_bits), 32'(want.bits));
                if (mismatch !== want.mismatch)
                    report_mismatch("mismatch", 32'(mismatch), 32'(want.mismatch));
            end
        end
    end

    always @(posedge clk)
    begin
        if (holdoff_left != 0)
            holdoff_left <= holdoff_left - 1;
        else if (holdoff_request)
        begin
            holdoff_left <= HOLDOFF_CYCLES;
            holdoff_request <= 1'b0;
        end
    end

    // stall style follows cycle_count bits 8:7; outside a hold-off, one style never stalls
    always @(posedge clk)
    begin
        if (holdoff_left != 0)
            out_ready <= 1'b0;
        else
            case (cycle_count[8:7])
                2'd0:    out_ready <= 1'b1;
                2'd1:    out_ready <= ($urandom_range(0, 1) == 1);
                2'd2:    out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= (cycle_count[2:0] != 3'd0);
            endcase
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("multi_mode_crc_checksum_unit regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic cmd, input logic [7:0] b, input logic [3:0] vb,
                             input logic lst, input logic [31:0] rx, input bit match_rx);
        msg_byte_t      it;
        checksum_step_t peek;
        it.cmd = cmd;
        it.data = b;
        it.vbits = vb;
        it.last = lst;
        it.rx = rx;
        if (match_rx && lst)
        begin
            // keep the junk above the check width, plant the right value below it
            peek = advance_checksum(checksum_state, it);
            it.rx = (rx & ~value_mask(checksum_state.mode)) | peek.res.value;
        end
        in_valid <= 1'b1;
        command <= it.cmd;
        data_byte <= it.data;
        valid_bits <= it.vbits;
        last <= it.last;
        received_check <= it.rx;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        peek = advance_checksum(checksum_state, it);
        checksum_state = peek.next;
        if (peek.emit)
            pending_results.push_back(peek.res);
        bytes_sent++;
        if (sender_gaps)
        begin
            if (burst_left == 0)
            begin
                in_valid <= 1'b0;
                command <= 1'($urandom_range(0, 1));
                data_byte <= 8'($urandom_range(0, 255));
                received_check <= $urandom();
                repeat ($urandom_range(1, 8))
                    @(posedge clk);
                burst_left = $urandom_range(0, 12);
            end
            else
                burst_left--;
        end
    endtask

    task automatic wait_idle;
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // a non-last byte may still be in the pipe with no result to show for it
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_mode(input logic [2:0] code);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_wdata <= code;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (code < MODE_LIMIT)
            checksum_state = fresh_checksum(mode_t'(code));
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_reset_mode;
        // CRC-8 out of reset; tail count on a non-last byte is ignored
        send_byte(CMD_GENERATE, 8'h00, 4'd3, 1'b0, 32'h0, 1'b0);
        send_byte(CMD_GENERATE, 8'hFF, FULL_BYTE, 1'b1, 32'h0, 1'b0);
        // empty message, matching value with the upper bits set
        send_byte(CMD_VERIFY, 8'hFF, 4'd0, 1'b1, 32'hFFFF_FF00, 1'b1);
    endtask

    task automatic test_spare_codes;
        write_mode(MODE_SPARE_LO);
        write_mode(MODE_SPARE_HI);
        // still CRC-8; oversized tail count saturates
        send_byte(CMD_VERIFY, 8'hA5, 4'd15, 1'b1, 32'h0000_0000, 1'b0);
    endtask

    task automatic test_crc_modes;
        write_mode(MODE_CRC16);
        send_byte(CMD_GENERATE, 8'h80, FULL_BYTE, 1'b0, 32'h0, 1'b0);
        send_byte(CMD_GENERATE, 8'h5A, 4'd5, 1'b1, 32'h0, 1'b0);
        write_mode(MODE_CRC32);
        send_byte(CMD_VERIFY, 8'hFF, FULL_BYTE, 1'b0, 32'h0, 1'b0);
        send_byte(CMD_VERIFY, 8'hFF, FULL_BYTE, 1'b0, 32'h0, 1'b0);
        send_byte(CMD_VERIFY, 8'h80, 4'd1, 1'b1, 32'h0, 1'b1);
        send_byte(CMD_VERIFY, 8'h00, 4'd0, 1'b1, 32'hFFFF_FFFF, 1'b0);
    endtask

    task automatic test_sum_modes;
        write_mode(MODE_SUM8);
        send_byte(CMD_GENERATE, 8'hFF, FULL_BYTE, 1'b0, 32'h0, 1'b0);
        send_byte(CMD_GENERATE, 8'hFF, 4'd9, 1'b1, 32'h0, 1'b0);
        send_byte(CMD_VERIFY, 8'h7E, 4'd0, 1'b1, 32'h0000_0001, 1'b0);
        write_mode(MODE_SUM16);
        // odd length: partial word is zero padded
        send_byte(CMD_GENERATE, 8'h12, FULL_BYTE, 1'b0, 32'h0, 1'b0);
        send_byte(CMD_GENERATE, 8'h34, FULL_BYTE, 1'b0, 32'h0, 1'b0);
        send_byte(CMD_VERIFY, 8'hFF, 4'd3, 1'b1, 32'hABCD_0000, 1'b1);
        write_mode(MODE_SUM32);
        send_byte(CMD_GENERATE, 8'hFF, FULL_BYTE, 1'b0, 32'h0, 1'b0);
        send_byte(CMD_GENERATE, 8'hFF, FULL_BYTE, 1'b0, 32'h0, 1'b0);
        send_byte(CMD_GENERATE, 8'hFF, FULL_BYTE, 1'b0, 32'h0, 1'b0);
        send_byte(CMD_VERIFY, 8'hFF, FULL_BYTE, 1'b1, 32'h0, 1'b1);
    endtask

    task automatic test_mode_write_restart;
        // half a message, then a write of the same mode drops it
        send_byte(CMD_GENERATE, 8'hAB, FULL_BYTE, 1'b0, 32'h0, 1'b0);
        write_mode(MODE_SUM32);
        send_byte(CMD_GENERATE, 8'h01, FULL_BYTE, 1'b1, 32'h0, 1'b0);
    endtask

    task automatic test_backpressure;
        int unsigned n;
        write_mode(MODE_CRC32);
        sender_gaps = 1'b0;
        holdoff_request = 1'b1;
        for (n = 0; n < 40; n++)
            send_byte(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                      4'($urandom_range(0, 15)), ($urandom_range(0, 3) != 0),
                      $urandom(), ($urandom_range(0, 1) == 1));
        sender_gaps = 1'b1;
    endtask

    task automatic test_random_traffic;
        int unsigned stop_at;
        int unsigned phase_end;
        int unsigned phase;
        int unsigned msg_len;
        int unsigned n;
        logic        lst;
        logic [3:0]  vb;
        stop_at = bytes_sent + RANDOM_ITEMS;
        phase = 0;
        while (bytes_sent < stop_at)
        begin
            // walk every mode once, then pick at random, spare codes included
            if (phase < 6)
                write_mode(3'(phase));
            else
                write_mode(3'($urandom_range(0, 7)));
            sender_gaps = (phase % 3 != 2);
            phase_end = bytes_sent + 70;
            while (bytes_sent < phase_end && bytes_sent < stop_at)
            begin
                msg_len = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 24)
                                                      : $urandom_range(1, 6);
                for (n = 0; n < msg_len; n++)
                begin
                    lst = (n == msg_len - 1);
                    if (!lst || $urandom_range(0, 2) != 0)
                        vb = lst ? FULL_BYTE : 4'($urandom_range(0, 15));
                    else
                        vb = 4'($urandom_range(0, 15));
                    send_byte(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), vb, lst,
                              $urandom(), ($urandom_range(0, 1) == 1));
                    // occasionally abandon the message with a mode write
                    if (!lst && $urandom_range(0, 39) == 0)
                    begin
                        write_mode(3'($urandom_range(0, 7)));
                        break;
                    end
                end
            end
            phase++;
        end
        sender_gaps = 1'b1;
    endtask

    initial
    begin
        checksum_state = fresh_checksum(MODE_CRC8);
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_mode();
        test_spare_codes();
        test_crc_modes();
        test_sum_modes();
        test_mode_write_restart();
        test_backpressure();
        test_random_traffic();
        wait_idle();
        repeat (8)
            @(posedge clk);
        if (error_count == 0)
            $display("multi_mode_crc_checksum_unit regression: pass");
        else
            $display("multi_mode_crc_checksum_unit regression: fail");
        $finish;
    end

endmodule

/* multi_mode_crc_checksum_unit.f */
+incdir+sv
sv/mmcrc_pkg.sv
sv/mmcrc_engine.sv
sv/multi_mode_crc_checksum_unit.sv
sim/tb_top.sv
